### sv/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key/value cache: item formats,
// register map and the command/status bundle between controller and datapath.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int KEY_W      = 32;
   localparam int VALUE_W    = 32;
   localparam int CFG_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

   localparam logic KIND_PUT = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_ACTIVE_ENTRIES = 1'b0;

   typedef struct packed {
      logic                      kind;
      logic signed [KEY_W-1:0]   lookup_key;
      logic signed [VALUE_W-1:0] store_value;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic signed [VALUE_W-1:0] read_value;
      logic                      evicted;
      logic signed [KEY_W-1:0]   evicted_key;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic issue;
      logic pass;
      logic commit;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic hit;
      logic put;
      logic rsp_busy;
   } status_type;

endpackage

### sv/lkvc_ram.sv
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer: search pass over all entries, decision, recency update pass on
// a hit or a put, then hand-off of the result item to the output register.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lkvc_pkg::status_type   status,
   output lkvc_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_DRAIN,
      S_DECIDE,
      S_PASS,
      S_PASS_DRAIN,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (status.last) begin
               state_in = S_SCAN_DRAIN;
            end
         end
         S_SCAN_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.commit = 1'b1;
            if (status.hit || status.put) begin
               state_in = S_PASS;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_PASS: begin
            cmd.issue = 1'b1;
            cmd.pass  = 1'b1;
            if (status.last) begin
               state_in = S_PASS_DRAIN;
            end
         end
         S_PASS_DRAIN: begin
            cmd.pass = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/lkvc_dpath.sv
// ----------------------------------------------------------------------------
// lkvc_dpath
// Datapath: key, value and rank memories, valid bits, occupancy, search
// trackers, rank update pass and the output register.
// ----------------------------------------------------------------------------
module lkvc_dpath #(
   parameter int ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lkvc_pkg::cmd_type             cmd,
   output lkvc_pkg::status_type          status,
   input  lkvc_pkg::req_type             req_data,
   input  logic [lkvc_pkg::CFG_W-1:0]    active_entries,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output lkvc_pkg::rsp_type             rsp_data
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > lkvc_pkg::CFG_W) ? CNT_W : lkvc_pkg::CFG_W;

   lkvc_pkg::req_type  req_ff;
   lkvc_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   logic [IDX_W-1:0]   addr_ff, probe_ff;
   logic               probe_v_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0]   occ_ff;

   logic               hit_ff, vic_ff, free_ff, evict_ff, age_all_ff;
   logic [IDX_W-1:0]   hit_idx_ff, vic_idx_ff, free_idx_ff, tgt_ff;
   logic [RANK_W-1:0]  hit_rank_ff, vic_rank_ff, limit_ff;
   logic [lkvc_pkg::KEY_W-1:0] vic_key_ff;

   logic [lkvc_pkg::KEY_W-1:0]   key_rd;
   logic [lkvc_pkg::VALUE_W-1:0] val_rd;
   logic [RANK_W-1:0]            rank_rd, rank_wd;
   logic                         rank_wr, key_wr, val_wr;

   logic               put, last, probe_valid_bit, key_match, scan_act, pass_act;
   logic               evict_now, at_tgt;
   logic [IDX_W-1:0]   tgt_in;
   logic [CMP_W-1:0]   occ_ext, act_ext, cap_ext;

   assign put             = (req_ff.kind == lkvc_pkg::KIND_PUT);
   assign last            = (addr_ff == IDX_W'(ENTRIES - 1));
   assign probe_valid_bit = valid_ff[probe_ff];
   assign key_match       = probe_valid_bit && (key_rd == $unsigned(req_ff.lookup_key));
   assign scan_act        = probe_v_ff && !cmd.pass;
   assign pass_act        = probe_v_ff && cmd.pass;

   // effective capacity: zero counts as one, saturates at ENTRIES
   assign occ_ext = CMP_W'(occ_ff);
   assign act_ext = CMP_W'(active_entries);
   always_comb begin
      priority if (act_ext == '0) begin
         cap_ext = CMP_W'(1);
      end else if (act_ext > CMP_W'(ENTRIES)) begin
         cap_ext = CMP_W'(ENTRIES);
      end else begin
         cap_ext = act_ext;
      end
   end

   assign evict_now = (occ_ext >= cap_ext);
   assign tgt_in    = hit_ff ? hit_idx_ff : (evict_now ? vic_idx_ff : free_idx_ff);
   assign key_wr    = cmd.commit && !hit_ff && put;
   assign val_wr    = cmd.commit && put;

   assign at_tgt  = (probe_ff == tgt_ff);
   assign rank_wr = pass_act &&
                    (at_tgt || (probe_valid_bit && (age_all_ff || (rank_rd < limit_ff))));
   assign rank_wd = at_tgt ? '0 : rank_rd + 1'b1;

   lkvc_ram #(.WIDTH(lkvc_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr),
      .wr_addr (tgt_in),
      .wr_data ($unsigned(req_ff.lookup_key)),
      .rd_addr (addr_ff),
      .rd_data (key_rd)
   );

   lkvc_ram #(.WIDTH(lkvc_pkg::VALUE_W), .DEPTH(ENTRIES)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr),
      .wr_addr (tgt_in),
      .wr_data ($unsigned(req_ff.store_value)),
      .rd_addr (hit_idx_ff),
      .rd_data (val_rd)
   );

   lkvc_ram #(.WIDTH(RANK_W), .DEPTH(ENTRIES)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_wr),
      .wr_addr (probe_ff),
      .wr_data (rank_wd),
      .rd_addr (addr_ff),
      .rd_data (rank_rd)
   );

   always_comb begin
      rsp_in.found       = hit_ff;
      rsp_in.read_value  = (hit_ff && !put) ? $signed(val_rd) : '0;
      rsp_in.evicted     = evict_ff;
      rsp_in.evicted_key = evict_ff ? $signed(vic_key_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         probe_v_ff   <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         hit_ff       <= 1'b0;
         vic_ff       <= 1'b0;
         free_ff      <= 1'b0;
         evict_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         probe_v_ff <= cmd.issue;
         if (cmd.issue) begin
            addr_ff <= last ? '0 : addr_ff + 1'b1;
         end
         if (cmd.accept) begin
            hit_ff   <= 1'b0;
            vic_ff   <= 1'b0;
            free_ff  <= 1'b0;
            evict_ff <= 1'b0;
         end
         if (scan_act) begin
            if (key_match && !hit_ff) begin
               hit_ff <= 1'b1;
            end
            if (probe_valid_bit && (!vic_ff || (rank_rd > vic_rank_ff))) begin
               vic_ff <= 1'b1;
            end
            if (!probe_valid_bit && !free_ff) begin
               free_ff <= 1'b1;
            end
         end
         if (cmd.commit && !hit_ff && put) begin
            valid_ff[tgt_in] <= 1'b1;
            evict_ff         <= evict_now;
            if (!evict_now) begin
               occ_ff <= occ_ff + 1'b1;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= addr_ff;
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (scan_act) begin
         if (key_match && !hit_ff) begin
            hit_idx_ff  <= probe_ff;
            hit_rank_ff <= rank_rd;
         end
         if (probe_valid_bit && (!vic_ff || (rank_rd > vic_rank_ff))) begin
            vic_idx_ff  <= probe_ff;
            vic_rank_ff <= rank_rd;
            vic_key_ff  <= key_rd;
         end
         if (!probe_valid_bit && !free_ff) begin
            free_idx_ff <= probe_ff;
         end
      end
      if (cmd.commit) begin
         tgt_ff     <= tgt_in;
         limit_ff   <= hit_rank_ff;
         age_all_ff <= !hit_ff;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      status.last     = last;
      status.hit      = hit_ff;
      status.put      = put;
      status.rsp_busy = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy does not match valid entries");

   a_insert_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !hit_ff && put |=> valid_ff[tgt_ff])
      else $error("inserted entry not marked valid");

   a_hit_keeps_occ: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && hit_ff |=> $stable(occ_ff))
      else $error("occupancy changed on a hit");

endmodule

### sv/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// One item at a time; a get miss skips the recency update pass. The result
//   loads into the output register once the output is not stalled, and the
//   next item is accepted the cycle after the result loads.
// Both passes walk the entry memories one entry per cycle through one read port.
// Reset: all entries invalid, occupancy zero, active_entries = 16; no clear pass.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lkvc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lkvc_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lkvc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lkvc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   logic [lkvc_pkg::CFG_W-1:0] active_ff;
   logic                       reg_sel;
   lkvc_pkg::cmd_type          cmd;
   lkvc_pkg::status_type       status;

   assign reg_sel = (paddr[2] == lkvc_pkg::REG_ACTIVE_ENTRIES);
   assign pready  = 1'b1;
   assign prdata  = reg_sel ? lkvc_pkg::CSR_DATA_W'(active_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= lkvc_pkg::ACTIVE_RESET;
      end else if (psel && penable && pwrite && pready && reg_sel) begin
         active_ff <= pwdata[lkvc_pkg::CFG_W-1:0];
      end
   end

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lkvc_dpath #(.ENTRIES(ENTRIES)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_data       (req_data),
      .active_entries (active_ff),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

endmodule
